// File: src/dcpd_pkg.sv
package dcpd_pkg;

  // Sequence phases of the detector.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_LOW      = 3'd2,
    PH_HIGH     = 3'd3,
    PH_PULSE    = 3'd4,
    PH_HOLDOFF  = 3'd5
  } phase_t;

  // Register indexes on the configuration port (byte address is 4 times the index).
  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_MAX_LOW  = 3'd1,
    REG_MAX_HIGH = 3'd2,
    REG_MIN_HIGH = 3'd3,
    REG_PULSE    = 3'd4,
    REG_HOLDOFF  = 3'd5
  } reg_index_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [15:0] MAX_LOW_RESET  = 16'd1000;
  localparam logic [15:0] MAX_HIGH_RESET = 16'd250;
  localparam logic [15:0] MIN_HIGH_RESET = 16'd80;
  localparam logic [15:0] PULSE_RESET    = 16'd200;
  localparam logic [15:0] HOLDOFF_RESET  = 16'd500;

  // Longest chain of phases one sample can walk through:
  // idle, debounce, low, high. A freshly entered high phase never hands the sample
  // on in the same tick, and high, pulse, holdoff is shorter.
  localparam int MAX_PASSES = 4;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] max_low_ticks;
    logic [15:0] max_high_ticks;
    logic [15:0] min_high_ticks;
    logic [15:0] pulse_ticks;
    logic [15:0] holdoff_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic busy_res;
    logic drive_level;
  } res_t;

endpackage

// File: src/dcpd_cfg.sv
module dcpd_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dcpd_pkg::cfg_t      cfg
);

  logic                 wr_en;
  dcpd_pkg::reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = dcpd_pkg::reg_index_t'(paddr[4:2]);

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= dcpd_pkg::DEBOUNCE_RESET;
      cfg.max_low_ticks  <= dcpd_pkg::MAX_LOW_RESET;
      cfg.max_high_ticks <= dcpd_pkg::MAX_HIGH_RESET;
      cfg.min_high_ticks <= dcpd_pkg::MIN_HIGH_RESET;
      cfg.pulse_ticks    <= dcpd_pkg::PULSE_RESET;
      cfg.holdoff_ticks  <= dcpd_pkg::HOLDOFF_RESET;
    end else if (wr_en) begin
      unique case (index)
        dcpd_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[15:0];
        dcpd_pkg::REG_MAX_LOW:  cfg.max_low_ticks  <= pwdata[15:0];
        dcpd_pkg::REG_MAX_HIGH: cfg.max_high_ticks <= pwdata[15:0];
        dcpd_pkg::REG_MIN_HIGH: cfg.min_high_ticks <= pwdata[15:0];
        dcpd_pkg::REG_PULSE:    cfg.pulse_ticks    <= pwdata[15:0];
        dcpd_pkg::REG_HOLDOFF:  cfg.holdoff_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (index)
      dcpd_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ticks};
      dcpd_pkg::REG_MAX_LOW:  prdata = {16'd0, cfg.max_low_ticks};
      dcpd_pkg::REG_MAX_HIGH: prdata = {16'd0, cfg.max_high_ticks};
      dcpd_pkg::REG_MIN_HIGH: prdata = {16'd0, cfg.min_high_ticks};
      dcpd_pkg::REG_PULSE:    prdata = {16'd0, cfg.pulse_ticks};
      dcpd_pkg::REG_HOLDOFF:  prdata = {16'd0, cfg.holdoff_ticks};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// File: src/dcpd_fsm.sv
module dcpd_fsm (
  input  logic               clk,
  input  logic               rst,
  input  dcpd_pkg::cfg_t     cfg,
  input  logic               in_valid_s,
  input  logic               in_level_s,
  output logic               in_ready,
  input  logic               res_space,
  output logic               res_push,
  output dcpd_pkg::res_t     res
);

  logic             in_valid;
  logic             in_level;
  dcpd_pkg::phase_t phase, phase_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [15:0]      high_count, high_count_next;
  logic             low_timed_out, low_timed_out_next;
  logic             previous_level;
  logic             drive;

  // The input stage is free when empty or when its sample is processed now.
  assign res_push = in_valid && res_space;
  assign in_ready = !in_valid || res_push;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= in_valid_s;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid_s) begin
      in_level <= in_level_s;
    end
  end

  // State register, advanced once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dcpd_pkg::PH_IDLE;
      tick_count     <= 16'd0;
      high_count     <= 16'd0;
      low_timed_out  <= 1'b0;
      previous_level <= 1'b1;
    end else if (res_push) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      high_count     <= high_count_next;
      low_timed_out  <= low_timed_out_next;
      previous_level <= in_level;
    end
  end

  // Next state. A phase that ends hands the same sample to the next phase,
  // so a few passes run back to back within one tick.
  always_comb begin
    logic again;
    phase_next         = phase;
    tick_count_next    = tick_count;
    high_count_next    = high_count;
    low_timed_out_next = low_timed_out;
    drive              = 1'b1;
    again              = 1'b1;
    for (int p = 0; p < dcpd_pkg::MAX_PASSES; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (phase_next)
          dcpd_pkg::PH_DEBOUNCE: begin
            if (tick_count_next >= cfg.debounce_ticks) begin
              phase_next      = dcpd_pkg::PH_LOW;
              tick_count_next = 16'd0;
              again           = 1'b1;
            end else begin
              tick_count_next = tick_count_next + 16'd1;
            end
          end
          dcpd_pkg::PH_LOW: begin
            if (tick_count_next >= cfg.max_low_ticks) begin
              low_timed_out_next = 1'b1;
              phase_next         = dcpd_pkg::PH_HIGH;
              high_count_next    = 16'd0;
              again              = 1'b1;
            end else if (!in_level) begin
              tick_count_next = tick_count_next + 16'd1;
            end else begin
              phase_next      = dcpd_pkg::PH_HIGH;
              high_count_next = 16'd0;
              again           = 1'b1;
            end
          end
          dcpd_pkg::PH_HIGH: begin
            if (high_count_next < cfg.max_high_ticks && in_level) begin
              high_count_next = high_count_next + 16'd1;
            end else if (high_count_next < cfg.max_high_ticks && !low_timed_out_next &&
                         high_count_next > cfg.min_high_ticks) begin
              phase_next      = dcpd_pkg::PH_PULSE;
              tick_count_next = 16'd0;
              again           = 1'b1;
            end else begin
              phase_next      = dcpd_pkg::PH_IDLE;
              tick_count_next = 16'd0;
            end
          end
          dcpd_pkg::PH_PULSE: begin
            if (tick_count_next >= cfg.pulse_ticks) begin
              phase_next      = dcpd_pkg::PH_HOLDOFF;
              tick_count_next = 16'd0;
              again           = 1'b1;
            end else begin
              drive           = 1'b0;
              tick_count_next = tick_count_next + 16'd1;
            end
          end
          dcpd_pkg::PH_HOLDOFF: begin
            if (tick_count_next >= cfg.holdoff_ticks) begin
              phase_next      = dcpd_pkg::PH_IDLE;
              tick_count_next = 16'd0;
            end else begin
              tick_count_next = tick_count_next + 16'd1;
            end
          end
          default: begin
            // Idle: a level change starts a new sequence.
            phase_next = dcpd_pkg::PH_IDLE;
            if (in_level != previous_level) begin
              phase_next         = dcpd_pkg::PH_DEBOUNCE;
              tick_count_next    = 16'd0;
              high_count_next    = 16'd0;
              low_timed_out_next = 1'b0;
              again              = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign res.drive_level = drive;
  assign res.busy_res    = (phase_next != dcpd_pkg::PH_IDLE);

endmodule

// File: src/dcpd_out_fifo.sv
module dcpd_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dcpd_pkg::res_t     push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output dcpd_pkg::res_t     out_data
);

  dcpd_pkg::res_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/double_click_pulse_detector.sv
// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/tready   s_tdata[0] switch_level
// m_*       out        m_tvalid/tready   m_tdata[0] drive_level, [1] busy_res
// APB       in/out     psel/penable      six 16-bit registers at 0x00..0x14
//
// One sample is taken per cycle while the result queue has space; each sample
// yields one result, which passes from the input register through the phase
// logic into the result queue.
// Reset is synchronous and active high; no clearing pass is needed.
// A stalled output fills the two-entry result queue and then the input register
// before s_tready drops, so no sample or result is lost.
module double_click_pulse_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] switch_level, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] drive_level, [1] busy_res, [7:2] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dcpd_pkg::cfg_t cfg;
  dcpd_pkg::res_t res;
  dcpd_pkg::res_t out_res;
  logic           res_space;
  logic           res_push;

  dcpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcpd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid_s (s_tvalid),
    .in_level_s (s_tdata[0]),
    .in_ready   (s_tready),
    .res_space  (res_space),
    .res_push   (res_push),
    .res        (res)
  );

  dcpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .space     (res_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res.busy_res, out_res.drive_level};

  // A low output level only ever occurs inside a running sequence.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || m_tdata[1]))
    else $error("drive low reported while idle");

  // The block is ready for a sample right after reset.
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // A processed sample always shows up on the output side.
  assert property (@(posedge clk) disable iff (rst) res_push |=> m_tvalid)
    else $error("pushed result not visible");

endmodule
